// ===== sv/ncpgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ncpgd_pkg : shared types, constants and functions
// widths, the classified queue entry, the back-end state type and the
// non-uniform ca cell update
// ----------------------------------------------------------------------------
package ncpgd_pkg;

   localparam int PIX_W   = 8;
   localparam int KEY_W   = 47;
   localparam int SEL_W   = 3;
   localparam int LANES   = 4;
   localparam int RANK_W  = 2;
   localparam int SPLIT_W = 3;
   localparam int CNT_W   = 4;

   localparam logic [PIX_W-1:0] RULE_LOW    = 8'd101;
   localparam logic [PIX_W-1:0] RULE_HIGH   = 8'd30;
   localparam logic [CNT_W-1:0] BASE_ROUNDS = 4'd8;

   // classified group, pixels held in rank order
   typedef struct packed {
      logic [LANES-1:0][PIX_W-1:0]    rpix;
      logic [LANES-2:0][SPLIT_W-1:0]  split;
      logic [LANES-1:0][RANK_W-1:0]   slot_rank;
      logic [SEL_W-1:0]               round_sel;
      logic [LANES-1:0][PIX_W-1:0]    mask;
   } entry_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qsts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // one wrapped 8-cell update, rule 101 below the split, rule 30 from it
   function automatic logic [PIX_W-1:0] ca_update(input logic [PIX_W-1:0]   v,
                                                  input logic [SPLIT_W-1:0] split);
      logic [PIX_W-1:0] r;
      logic [2:0]       idx;
      logic [2:0]       nb;
      r = '0;
      for (int i = 0; i < PIX_W; i++) begin
         idx   = 3'(i);
         nb    = {v[3'(idx - 3'd1)], v[idx], v[3'(idx + 3'd1)]};
         r[i]  = (idx < split) ? RULE_LOW[nb] : RULE_HIGH[nb];
      end
      return r;
   endfunction

endpackage

// ===== sv/ncpgd_req_if.sv =====
// ----------------------------------------------------------------------------
// ncpgd_req_if : request channel
// valid/ready channel carrying one cipher pixel group with its keys
// ----------------------------------------------------------------------------
interface ncpgd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ncpgd_pkg::PIX_W-1:0]   pixel_a;
   logic [ncpgd_pkg::PIX_W-1:0]   pixel_b;
   logic [ncpgd_pkg::PIX_W-1:0]   pixel_c;
   logic [ncpgd_pkg::PIX_W-1:0]   pixel_d;
   logic [ncpgd_pkg::KEY_W-1:0]   key_a;
   logic [ncpgd_pkg::KEY_W-1:0]   key_b;
   logic [ncpgd_pkg::KEY_W-1:0]   key_c;
   logic [ncpgd_pkg::KEY_W-1:0]   key_d;
   logic [ncpgd_pkg::SEL_W-1:0]   round_sel;
   logic                          start_of_image;

   modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d,
                   key_a, key_b, key_c, key_d, round_sel, start_of_image,
                   input ready);
   modport sink   (input valid, pixel_a, pixel_b, pixel_c, pixel_d,
                   key_a, key_b, key_c, key_d, round_sel, start_of_image,
                   output ready);
endinterface

// ===== sv/ncpgd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ncpgd_rsp_if : response channel
// valid/ready channel carrying one decrypted pixel group
// ----------------------------------------------------------------------------
interface ncpgd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ncpgd_pkg::PIX_W-1:0]   plain_a;
   logic [ncpgd_pkg::PIX_W-1:0]   plain_b;
   logic [ncpgd_pkg::PIX_W-1:0]   plain_c;
   logic [ncpgd_pkg::PIX_W-1:0]   plain_d;

   modport source (output valid, plain_a, plain_b, plain_c, plain_d, input ready);
   modport sink   (input valid, plain_a, plain_b, plain_c, plain_d, output ready);
endinterface

// ===== sv/nonuniform_ca_pixel_group_decrypt_unit.sv =====
// ----------------------------------------------------------------------------
// nonuniform_ca_pixel_group_decrypt_unit : four-pixel group decryptor
// keyed non-uniform cellular automaton decryption of one pixel group
// ----------------------------------------------------------------------------
// Each request carries four cipher pixels, one 47-bit key per pixel, a round
// selector and a start-of-image flag; each request gives one response with
// the four plain pixels in the same slot order. Pixels are ranked by key in
// ascending order, equal keys keeping slot order a, b, c, d. The round engine
// then runs 8 + round_sel rounds, one round per clock, and the result is
// XORed with the raw cipher pixels of the previous request (zero after reset
// or when start_of_image is set). A group is registered in the front
// stage, where ranking is done, then the round engine loads it, runs the
// rounds and writes the response register. The round engine sets the
// sustained rate; a two-entry queue lets the front take new requests while
// the engine runs, and the response register lets the engine finish while
// a response waits.
module nonuniform_ca_pixel_group_decrypt_unit (
   input  logic         clock,
   input  logic         reset,
   ncpgd_req_if.sink    req_chan,
   ncpgd_rsp_if.source  rsp_chan
);

   ncpgd_pkg::qctl_type  q_ctl;
   ncpgd_pkg::qsts_type  q_sts;
   ncpgd_pkg::entry_type q_wr_entry;
   ncpgd_pkg::entry_type q_rd_entry;
   logic                 front_push;
   logic                 back_pop;

   // intake: registers the request and ranks it
   ncpgd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_sts    (q_sts),
      .push     (front_push),
      .entry    (q_wr_entry)
   );

   assign q_ctl.push = front_push;
   assign q_ctl.pop  = back_pop;

   // decouples intake from the round engine
   ncpgd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .wr_entry (q_wr_entry),
      .sts      (q_sts),
      .rd_entry (q_rd_entry)
   );

   // round engine and response register
   ncpgd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_sts    (q_sts),
      .entry    (q_rd_entry),
      .pop      (back_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/ncpgd_queue.sv =====
// ----------------------------------------------------------------------------
// ncpgd_queue : two-entry queue
// holds classified groups between the front and back ends
// ----------------------------------------------------------------------------
module ncpgd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  ncpgd_pkg::qctl_type  ctl,
   input  ncpgd_pkg::entry_type wr_entry,
   output ncpgd_pkg::qsts_type  sts,
   output ncpgd_pkg::entry_type rd_entry
);

   ncpgd_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ ctl.push;
      rd_ptr_in = rd_ptr_ff ^ ctl.pop;
      count_in  = count_ff + 2'(ctl.push) - 2'(ctl.pop);
   end

   assign sts.full  = (count_ff == 2'd2);
   assign sts.empty = (count_ff == 2'd0);
   assign rd_entry  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== sv/ncpgd_front.sv =====
// ----------------------------------------------------------------------------
// ncpgd_front : request intake and key ranking
// registers a request, ranks the pixels by key and pushes the group
// ----------------------------------------------------------------------------
module ncpgd_front (
   input  logic                 clock,
   input  logic                 reset,
   ncpgd_req_if.sink            req_chan,
   input  ncpgd_pkg::qsts_type  q_sts,
   output logic                 push,
   output ncpgd_pkg::entry_type entry
);

   localparam int L = ncpgd_pkg::LANES;

   logic                                  hold_ff;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]    pix_ff;
   logic [L-1:0][ncpgd_pkg::KEY_W-1:0]    key_ff;
   logic [ncpgd_pkg::SEL_W-1:0]           sel_ff;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]    mask_ff;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]    prev_ff, prev_in;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]    raw;
   logic [L-1:0][ncpgd_pkg::KEY_W-1:0]    key_raw;
   logic [L-1:0][ncpgd_pkg::RANK_W-1:0]   rank;
   logic                                  accept;

   assign raw     = {req_chan.pixel_d, req_chan.pixel_c, req_chan.pixel_b, req_chan.pixel_a};
   assign key_raw = {req_chan.key_d, req_chan.key_c, req_chan.key_b, req_chan.key_a};

   assign push           = hold_ff && !q_sts.full;
   assign req_chan.ready = !hold_ff || push;
   assign accept         = req_chan.valid && req_chan.ready;

   // previous-pixel store, loaded with the raw pixels of every accepted request
   always_comb begin
      prev_in = prev_ff;
      if (accept) begin
         prev_in = raw;
      end
   end

   // stable ascending rank: smaller keys, plus equal keys in earlier slots
   always_comb begin
      for (int s = 0; s < L; s++) begin
         rank[s] = '0;
         for (int j = 0; j < L; j++) begin
            if (j != s) begin
               rank[s] = rank[s] + ncpgd_pkg::RANK_W'((key_ff[j] < key_ff[s]) ||
                                                      ((j < s) && (key_ff[j] == key_ff[s])));
            end
         end
      end
   end

   always_comb begin
      entry           = '0;
      entry.slot_rank = rank;
      entry.round_sel = sel_ff;
      entry.mask      = mask_ff;
      for (int k = 0; k < L; k++) begin
         for (int s = 0; s < L; s++) begin
            if (rank[s] == ncpgd_pkg::RANK_W'(k)) begin
               entry.rpix[k] = entry.rpix[k] | pix_ff[s];
            end
         end
      end
      // split for rank k-1 comes from the key at rank k
      for (int k = 1; k < L; k++) begin
         for (int s = 0; s < L; s++) begin
            if (rank[s] == ncpgd_pkg::RANK_W'(k)) begin
               entry.split[k-1] = entry.split[k-1] | key_ff[s][ncpgd_pkg::SPLIT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         hold_ff <= accept || (hold_ff && !push);
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= raw;
         key_ff  <= key_raw;
         sel_ff  <= req_chan.round_sel;
         mask_ff <= req_chan.start_of_image ? '0 : prev_ff;
      end
   end

endmodule

// ===== sv/ncpgd_back.sv =====
// ----------------------------------------------------------------------------
// ncpgd_back : round engine and response register
// runs one ca round per cycle and returns the pixels to slot order
// ----------------------------------------------------------------------------
module ncpgd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ncpgd_pkg::qsts_type  q_sts,
   input  ncpgd_pkg::entry_type entry,
   output logic                 pop,
   ncpgd_rsp_if.source          rsp_chan
);

   localparam int L = ncpgd_pkg::LANES;

   ncpgd_pkg::state_type                   state_ff, state_in;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]     rpix_ff, rpix_in;
   logic [L-2:0][ncpgd_pkg::SPLIT_W-1:0]   split_ff, split_in;
   logic [L-1:0][ncpgd_pkg::RANK_W-1:0]    rank_ff, rank_in;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]     mask_ff, mask_in;
   logic [ncpgd_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]     plain_ff, plain_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [ncpgd_pkg::PIX_W-1:0]            mix;
   logic [L-1:0][ncpgd_pkg::PIX_W-1:0]     unranked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncpgd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rpix_ff  <= rpix_in;
      split_ff <= split_in;
      rank_ff  <= rank_in;
      mask_ff  <= mask_in;
      count_ff <= count_in;
      plain_ff <= plain_in;
   end

   always_comb begin
      mix = ncpgd_pkg::ca_update(rpix_ff[0], split_ff[0]) ^
            ncpgd_pkg::ca_update(rpix_ff[1], split_ff[1]) ^
            ncpgd_pkg::ca_update(rpix_ff[2], split_ff[2]) ^ rpix_ff[3];
      for (int s = 0; s < L; s++) begin
         unranked[s] = '0;
         for (int k = 0; k < L; k++) begin
            if (rank_ff[s] == ncpgd_pkg::RANK_W'(k)) begin
               unranked[s] = unranked[s] | rpix_ff[k];
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rpix_in      = rpix_ff;
      split_in     = split_ff;
      rank_in      = rank_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      plain_in     = plain_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      unique case (state_ff)
         ncpgd_pkg::ST_IDLE: begin
            if (!q_sts.empty) begin
               pop      = 1'b1;
               rpix_in  = entry.rpix;
               split_in = entry.split;
               rank_in  = entry.slot_rank;
               mask_in  = entry.mask;
               count_in = ncpgd_pkg::BASE_ROUNDS + ncpgd_pkg::CNT_W'(entry.round_sel);
               state_in = ncpgd_pkg::ST_RUN;
            end
         end
         ncpgd_pkg::ST_RUN: begin
            rpix_in  = {rpix_ff[2], rpix_ff[1], rpix_ff[0], mix};
            count_in = count_ff - ncpgd_pkg::CNT_W'(1);
            if (count_ff == ncpgd_pkg::CNT_W'(1)) begin
               state_in = ncpgd_pkg::ST_DONE;
            end
         end
         ncpgd_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               for (int s = 0; s < L; s++) begin
                  plain_in[s] = unranked[s] ^ mask_ff[s];
               end
               out_valid_in = 1'b1;
               state_in     = ncpgd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ncpgd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.plain_a = plain_ff[0];
   assign rsp_chan.plain_b = plain_ff[1];
   assign rsp_chan.plain_c = plain_ff[2];
   assign rsp_chan.plain_d = plain_ff[3];

endmodule

// ===== tb/nonuniform_ca_pixel_group_decrypt_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonuniform_ca_pixel_group_decrypt_unit_tb : self-checking testbench
// drives cipher pixel groups with keys through the request channel, predicts
// each decrypted group with an independent ranking and automaton model, and
// checks every response in order under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module nonuniform_ca_pixel_group_decrypt_unit_tb;

   localparam time         CLK_PERIOD     = 20ns;
   localparam int unsigned RANDOM_GROUPS  = 1950;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned REPORT_LIMIT   = 10;

   localparam int LANES = ncpgd_pkg::LANES;
   localparam int PIX_W = ncpgd_pkg::PIX_W;
   localparam int KEY_W = ncpgd_pkg::KEY_W;
   localparam int SEL_W = ncpgd_pkg::SEL_W;

   // largest in-range key and the all-ones field, which lies beyond range
   localparam logic [KEY_W-1:0] KEY_TOP  = 47'd99999999999999;
   localparam logic [KEY_W-1:0] KEY_ONES = '1;
   localparam logic [63:0]      KEY_SPAN = 64'd100000000000000;

   // key flavours for random groups
   localparam int unsigned KEYS_IN_RANGE = 0;
   localparam int unsigned KEYS_FULL     = 1;
   localparam int unsigned KEYS_TIED     = 2;

   typedef logic [LANES-1:0][PIX_W-1:0] pixel_quad_type;
   typedef logic [LANES-1:0][KEY_W-1:0] key_quad_type;

   // one request as the sender sees it, lane 0 is slot a
   typedef struct packed {
      pixel_quad_type   pix;
      key_quad_type     key;
      logic [SEL_W-1:0] round_sel;
      logic             start;
   } cipher_group_type;

   logic clock = 1'b0;
   logic reset;

   ncpgd_req_if req_chan ();
   ncpgd_rsp_if rsp_chan ();

   nonuniform_ca_pixel_group_decrypt_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor state: raw cipher pixels of the last accepted group
   pixel_quad_type prev_cipher;
   // decrypted groups still owed by the block, oldest first
   pixel_quad_type plain_expected [$];

   int unsigned mismatch_count = 0;
   int unsigned burst_left     = 0;
   logic        gaps_on        = 1'b1;
   string       lane_tag [LANES] = '{"a", "b", "c", "d"};

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // wrapped 8-cell step: rule 101 for cells below the split, rule 30 from it up
   function automatic logic [PIX_W-1:0] ca_rule_step(input logic [PIX_W-1:0] cells,
                                                     input logic [2:0]       split);
      logic [PIX_W-1:0] nxt;
      logic [PIX_W-1:0] rule;
      logic [2:0]       hood;
      nxt = '0;
      for (int i = 0; i < PIX_W; i++) begin
         hood   = {cells[(i + PIX_W - 1) % PIX_W], cells[i], cells[(i + 1) % PIX_W]};
         rule   = (i < int'(split)) ? ncpgd_pkg::RULE_LOW : ncpgd_pkg::RULE_HIGH;
         nxt[i] = rule[hood];
      end
      return nxt;
   endfunction

   // full decryption of one group, advancing the previous-pixel store
   function automatic pixel_quad_type decrypt_group(input cipher_group_type g);
      pixel_quad_type cells;
      pixel_quad_type held;
      pixel_quad_type plain;
      int unsigned    order [LANES];
      int unsigned    rank;
      int unsigned    rounds;
      // stable ascending ranking: count keys strictly lower, or equal and earlier
      for (int s = 0; s < LANES; s++) begin
         rank = 0;
         for (int j = 0; j < LANES; j++) begin
            if (g.key[j] < g.key[s] || (g.key[j] == g.key[s] && j < s)) begin
               rank++;
            end
         end
         order[rank] = s;
      end
      if (g.start) begin
         prev_cipher = '0;
      end
      cells  = g.pix;
      rounds = int'(ncpgd_pkg::BASE_ROUNDS) + int'(g.round_sel);
      for (int t = 0; t < rounds; t++) begin
         held = cells;
         // ranks 0..2 step with the split from the next rank's key
         for (int r = 0; r < LANES - 1; r++) begin
            cells[order[r]] = ca_rule_step(cells[order[r]], g.key[order[r + 1]][2:0]);
         end
         // lowest rank folds in the whole group, the rest shift up by one rank
         cells[order[0]] = cells[0] ^ cells[1] ^ cells[2] ^ cells[3];
         for (int r = 1; r < LANES; r++) begin
            cells[order[r]] = held[order[r - 1]];
         end
      end
      plain       = cells ^ prev_cipher;
      prev_cipher = g.pix;
      return plain;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic cipher_group_type group_of(input pixel_quad_type   pix,
                                                 input key_quad_type     key,
                                                 input logic [SEL_W-1:0] round_sel,
                                                 input logic             start);
      cipher_group_type g;
      g.pix       = pix;
      g.key       = key;
      g.round_sel = round_sel;
      g.start     = start;
      return g;
   endfunction

   function automatic logic [KEY_W-1:0] random_key(input int unsigned flavour);
      logic [63:0]      wide;
      logic [KEY_W-1:0] k;
      wide = {$urandom, $urandom};
      if (flavour == KEYS_IN_RANGE) begin
         k = KEY_W'(wide % KEY_SPAN);
      end else if (flavour == KEYS_FULL) begin
         k = wide[KEY_W-1:0];
      end else begin
         // small pool so that ties come up often
         case ($urandom_range(0, 6))
            0: k = '0;
            1: k = 47'd1;
            2: k = 47'd7;
            3: k = 47'd8;
            4: k = KEY_TOP;
            5: k = KEY_ONES;
            default: k = 47'd5000;
         endcase
      end
      return k;
   endfunction

   function automatic cipher_group_type random_group(input logic start);
      cipher_group_type g;
      int unsigned      pick;
      int unsigned      flavour;
      pick    = $urandom_range(0, 19);
      flavour = (pick < 12) ? KEYS_IN_RANGE : (pick < 17) ? KEYS_FULL : KEYS_TIED;
      for (int s = 0; s < LANES; s++) begin
         g.pix[s] = PIX_W'($urandom);
         g.key[s] = random_key(flavour);
      end
      g.round_sel = SEL_W'($urandom);
      g.start     = start;
      return g;
   endfunction

   // one request: optional gap at a burst boundary, then hold until accepted
   task automatic send_group(input cipher_group_type g);
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0) begin
         burst_left--;
      end
      req_chan.pixel_a        <= g.pix[0];
      req_chan.pixel_b        <= g.pix[1];
      req_chan.pixel_c        <= g.pix[2];
      req_chan.pixel_d        <= g.pix[3];
      req_chan.key_a          <= g.key[0];
      req_chan.key_b          <= g.key[1];
      req_chan.key_c          <= g.key[2];
      req_chan.key_d          <= g.key[3];
      req_chan.round_sel      <= g.round_sel;
      req_chan.start_of_image <= g.start;
      req_chan.valid          <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      // accepted at this edge: the store advances in acceptance order
      plain_expected.push_back(decrypt_group(g));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // zero and all-ones pixels, in-range and beyond-range keys, both round extremes
   task automatic test_field_extremes();
      send_group(group_of('0, '0, 3'd0, 1'b1));
      send_group(group_of('1, {LANES{KEY_TOP}}, 3'd7, 1'b0));
      send_group(group_of('1, {LANES{KEY_ONES}}, 3'd7, 1'b0));
      send_group(group_of('0, {KEY_ONES, 47'd0, KEY_ONES, 47'd0}, 3'd0, 1'b0));
      // keys descending in slot order, so the ranking fully reverses
      send_group(group_of({8'hF0, 8'h0F, 8'hAA, 8'h55},
                          {47'd1, 47'd2, 47'd3, 47'd4}, 3'd5, 1'b0));
   endtask

   // every round count, with the low key bits walking through every split
   task automatic test_round_counts();
      key_quad_type keys;
      for (int sel = 0; sel < 8; sel++) begin
         keys = {47'(sel), 47'(1000 + 5 * sel), 47'(3 * sel + 1), 47'(KEY_TOP - 47'(sel))};
         send_group(group_of({PIX_W'($urandom), PIX_W'($urandom),
                              PIX_W'($urandom), PIX_W'($urandom)},
                             keys, SEL_W'(sel), 1'b0));
      end
   endtask

   // equal keys must keep slot order
   task automatic test_key_ties();
      send_group(group_of({8'h81, 8'h42, 8'h24, 8'h18}, {LANES{47'd12345}}, 3'd2, 1'b0));
      send_group(group_of({8'h01, 8'h80, 8'hFE, 8'h7F},
                          {47'd9, 47'd4, 47'd9, 47'd4}, 3'd6, 1'b0));
      send_group(group_of({8'hC3, 8'h3C, 8'h99, 8'h66},
                          {47'd77, 47'd77, 47'd2, 47'd77}, 3'd1, 1'b0));
      send_group(group_of({8'h13, 8'h57, 8'h9B, 8'hDF},
                          {47'd6, KEY_ONES, KEY_ONES, 47'd6}, 3'd4, 1'b0));
   endtask

   // start of image mid-stream, back to back and followed by a normal group
   task automatic test_image_restart();
      send_group(random_group(1'b0));
      send_group(random_group(1'b1));
      send_group(random_group(1'b1));
      send_group(random_group(1'b0));
   endtask

   // whole images: a start group then a run of ordinary groups, with stray starts
   task automatic test_random_images(input int unsigned count);
      int unsigned sent;
      int unsigned image_len;
      sent = 0;
      while (sent < count) begin
         image_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
         gaps_on   = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < image_len && sent < count; n++) begin
            send_group(random_group(n == 0 || $urandom_range(0, 31) == 0));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                   = 1'b1;
      prev_cipher             = '0;
      req_chan.valid          = 1'b0;
      req_chan.pixel_a        = '0;
      req_chan.pixel_b        = '0;
      req_chan.pixel_c        = '0;
      req_chan.pixel_d        = '0;
      req_chan.key_a          = '0;
      req_chan.key_b          = '0;
      req_chan.key_c          = '0;
      req_chan.key_d          = '0;
      req_chan.round_sel      = '0;
      req_chan.start_of_image = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_round_counts();
      test_key_ties();
      test_image_restart();
      test_random_images(RANDOM_GROUPS);
      req_chan.valid <= 1'b0;

      // drain, then give the block time to show any stray response
      while (plain_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && plain_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // response side: own stall pattern plus in-order checking
   // ---------------------------------------------------------------------
   initial begin : response_side
      int unsigned    hold;
      int unsigned    pick;
      pixel_quad_type seen;
      pixel_quad_type want;
      hold           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            seen = {rsp_chan.plain_d, rsp_chan.plain_c, rsp_chan.plain_b, rsp_chan.plain_a};
            if (plain_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: response %h with nothing outstanding", seen);
               end
            end else begin
               want = plain_expected.pop_front();
               for (int i = 0; i < LANES; i++) begin
                  if (seen[i] !== want[i]) begin
                     mismatch_count++;
                     if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: plain_%s expected %02h got %02h",
                                 lane_tag[i], want[i], seen[i]);
                     end
                  end
               end
            end
         end
         // stretches of ready, short and long stalls, and the odd long clear run
         if (hold == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(1, 40);
            end else if (pick < 8) begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(1, 6);
            end else if (pick < 9) begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(10, 24);
            end else begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(150, 300);
            end
         end else begin
            hold--;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any handshake on either channel
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready)
             || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
